// File: rtl/core/pgs_pkg.sv
// Package for the projected gradient step pipeline: field widths, codes and payload types.
// Used by every module under rtl/core; it depends on nothing else.
package pgs_pkg;

  // Number of coordinates per point; the payload structs below carry exactly this many.
  localparam int DIM = 3;

  localparam int XW = 32;           // coordinate width, signed Q3.28
  localparam int GW = 48;           // gradient width, signed Q23.24
  localparam int SW = 64;           // squared norm and remainder width
  localparam int NS = 32;           // square root stages, one result bit each
  localparam int QW = 32;           // quotient bits produced by the divider
  localparam int RW = 28;           // target radius width, Q.27

  // Projection modes; the unused code behaves as ball.
  typedef enum logic [1:0] {
    MODE_BALL   = 2'd0,
    MODE_SHELL  = 2'd1,
    MODE_SPHERE = 2'd2
  } pgs_mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_STEP = 2'd1,
    CFG_IRAD = 2'd2
  } pgs_cfg_idx_t;

  typedef struct packed {
    logic signed [XW-1:0] pos_0;
    logic signed [XW-1:0] pos_1;
    logic signed [XW-1:0] pos_2;
    logic signed [GW-1:0] grad_0;
    logic signed [GW-1:0] grad_1;
    logic signed [GW-1:0] grad_2;
    logic [15:0]          point_tag;
    logic                 in_last;
  } pgs_in_t;

  typedef struct packed {
    logic signed [XW-1:0] new_0;
    logic signed [XW-1:0] new_1;
    logic signed [XW-1:0] new_2;
    logic [15:0]          out_tag;
    logic                 out_last;
    logic                 degenerate;
  } pgs_out_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] step;
    logic [15:0] irad;
  } pgs_cfg_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        last;
  } pgs_meta_t;

  typedef logic [DIM-1:0][XW-1:0] pgs_vec_t;

  // Sideband that rides along with the square root.
  typedef struct packed {
    pgs_vec_t      x;
    logic          need;
    logic [RW-1:0] rq;
    pgs_meta_t     meta;
  } pgs_side_t;

  // Sideband that rides along with the divider.
  typedef struct packed {
    pgs_vec_t  x;
    logic      scale;
    logic      deg;
    pgs_meta_t meta;
  } pgs_dside_t;

endpackage

// File: rtl/core/projected_gradient_step.sv
// Projected gradient step: new point = pos - step * grad, then ball, shell or sphere projection.
// Stages in order: descent step, squared norm, square root, radius product, overflow check, divide, output.
// Throughput is one point per cycle; the whole pipeline holds while a result waits untaken.
// Reset (rst_n low, synchronous) clears all valid bits and the configuration registers.
// Depends on pgs_pkg, pgs_step, pgs_norm, pgs_sqrt and pgs_scale.
module projected_gradient_step import pgs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  pgs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pgs_out_t    out_data
);

  logic [1:0]             mode_r;
  logic [31:0]            step_r;
  logic [15:0]            irad_r;
  pgs_cfg_t               cfg;
  logic                   adv;

  pgs_vec_t               pos_in;
  logic [DIM-1:0][GW-1:0] grad_in;
  pgs_meta_t              meta_in;

  logic                   v_step, v_norm, v_sqrt;
  pgs_vec_t               x_step;
  pgs_meta_t              meta_step;
  logic [SW-1:0]          s_norm;
  pgs_side_t              side_norm, side_sqrt;
  logic [31:0]            n_sqrt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BALL;
      step_r <= '0;
      irad_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE: mode_r <= cfg_wdata[1:0];
        CFG_STEP: step_r <= cfg_wdata;
        CFG_IRAD: irad_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.mode = mode_r;
  assign cfg.step = step_r;
  assign cfg.irad = irad_r;

  // The pipeline moves unless a finished result is held by the consumer.
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // Unpack the input transfer.
  assign pos_in[0]    = in_data.pos_0;
  assign pos_in[1]    = in_data.pos_1;
  assign pos_in[2]    = in_data.pos_2;
  assign grad_in[0]   = in_data.grad_0;
  assign grad_in[1]   = in_data.grad_1;
  assign grad_in[2]   = in_data.grad_2;
  assign meta_in.tag  = in_data.point_tag;
  assign meta_in.last = in_data.in_last;

  pgs_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (in_valid),
    .pos_in   (pos_in),
    .grad_in  (grad_in),
    .meta_in  (meta_in),
    .step     (cfg.step),
    .v_out    (v_step),
    .x_out    (x_step),
    .meta_out (meta_step)
  );

  pgs_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (v_step),
    .x_in     (x_step),
    .meta_in  (meta_step),
    .cfg      (cfg),
    .v_out    (v_norm),
    .s_out    (s_norm),
    .side_out (side_norm)
  );

  pgs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (v_norm),
    .s_in     (s_norm),
    .side_in  (side_norm),
    .v_out    (v_sqrt),
    .n_out    (n_sqrt),
    .side_out (side_sqrt)
  );

  pgs_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (v_sqrt),
    .n_in     (n_sqrt),
    .side_in  (side_sqrt),
    .v_out    (out_valid),
    .out_data (out_data)
  );

`ifndef SYNTH
  // A degenerate point has a zero norm, so every coordinate is within one LSB of zero.
  a_degenerate_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      (out_data.new_0 == 32'sd0 || out_data.new_0 == 32'sd1 || out_data.new_0 == -32'sd1) &&
      (out_data.new_1 == 32'sd0 || out_data.new_1 == 32'sd1 || out_data.new_1 == -32'sd1) &&
      (out_data.new_2 == 32'sd0 || out_data.new_2 == 32'sd1 || out_data.new_2 == -32'sd1))
    else $error("degenerate result with a nonzero norm");

  // A sphere projection that is not degenerate never returns the origin.
  a_sphere_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == MODE_SPHERE) && !out_data.degenerate |->
      (out_data.new_0 != 32'sd0 || out_data.new_1 != 32'sd0 || out_data.new_2 != 32'sd0))
    else $error("sphere projection returned the origin");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// File: rtl/core/pgs_step.sv
// Descent step stages: gradient magnitude, step product and saturating subtract.
// Depends on pgs_pkg.
module pgs_step import pgs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  pgs_vec_t                pos_in,
  input  logic [DIM-1:0][GW-1:0]  grad_in,
  input  pgs_meta_t               meta_in,
  input  logic [31:0]             step,
  output logic                    v_out,
  output pgs_vec_t                x_out,
  output pgs_meta_t               meta_out
);

  localparam logic signed [54:0] MAX32 = 55'sd2147483647;
  localparam logic signed [54:0] MIN32 = -55'sd2147483648;

  logic                   v1_r, v2_r, v3_r;
  pgs_vec_t               pos1_r, pos2_r;
  logic [DIM-1:0]         gneg1_r, gneg2_r;
  logic [DIM-1:0]         gneg1_nxt;
  logic [DIM-1:0][GW-1:0] gmag1_r, gmag1_nxt;
  logic [DIM-1:0][55:0]   ph2_r, pl2_r, ph2_nxt, pl2_nxt;
  pgs_vec_t               x3_r, x3_nxt;
  pgs_meta_t              meta1_r, meta2_r, meta3_r;

  // Stage 1: sign and magnitude of each gradient component.
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      gneg1_nxt[j] = grad_in[j][GW-1];
      gmag1_nxt[j] = grad_in[j][GW-1] ? (~grad_in[j] + GW'(1)) : grad_in[j];
    end
  end

  // Stage 2: step times the high and low halves of the magnitude.
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      ph2_nxt[j] = 56'(step) * 56'(gmag1_r[j][47:24]);
      pl2_nxt[j] = 56'(step) * 56'(gmag1_r[j][23:0]);
    end
  end

  // Stage 3: round the product to Q.28, apply it and saturate.
  always_comb begin
    logic [56:0]        low;
    logic [52:0]        d;
    logic signed [54:0] pe, de, sum;
    for (int j = 0; j < DIM; j++) begin
      low = 57'({ph2_r[j][3:0], 24'b0}) + 57'(pl2_r[j]) + (57'(1) << 27);
      d   = 53'(ph2_r[j][55:4]) + 53'(low[56:28]);
      pe  = 55'($signed(pos2_r[j]));
      de  = $signed({2'b00, d});
      sum = gneg2_r[j] ? (pe + de) : (pe - de);
      if (sum > MAX32) begin
        x3_nxt[j] = 32'h7FFF_FFFF;
      end else if (sum < MIN32) begin
        x3_nxt[j] = 32'h8000_0000;
      end else begin
        x3_nxt[j] = sum[31:0];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r  <= pos_in;
      gneg1_r <= gneg1_nxt;
      gmag1_r <= gmag1_nxt;
      meta1_r <= meta_in;
      pos2_r  <= pos1_r;
      gneg2_r <= gneg1_r;
      ph2_r   <= ph2_nxt;
      pl2_r   <= pl2_nxt;
      meta2_r <= meta1_r;
      x3_r    <= x3_nxt;
      meta3_r <= meta2_r;
    end
  end

  assign v_out    = v3_r;
  assign x_out    = x3_r;
  assign meta_out = meta3_r;

endmodule

// File: rtl/core/pgs_norm.sv
// Squared norm stages and the projection decision (which radius, if any).
// Depends on pgs_pkg.
module pgs_norm import pgs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_in,
  input  pgs_vec_t        x_in,
  input  pgs_meta_t       meta_in,
  input  pgs_cfg_t        cfg,
  output logic            v_out,
  output logic [SW-1:0]   s_out,
  output pgs_side_t       side_out
);

  logic                   v4_r, v5_r, v6_r;
  pgs_vec_t               x4_r, x5_r;
  pgs_meta_t              meta4_r, meta5_r;
  logic [DIM-1:0][60:0]   q4_r, q4_nxt;
  logic [SW-1:0]          s5_r, s5_nxt, s6_r;
  pgs_side_t              side6_r, side6_nxt;

  // Stage 4: each coordinate squared, quartered.
  always_comb begin
    logic [31:0] mag;
    logic [63:0] sq;
    for (int j = 0; j < DIM; j++) begin
      mag       = x_in[j][XW-1] ? (~x_in[j] + 32'd1) : x_in[j];
      sq        = 64'(mag) * 64'(mag);
      q4_nxt[j] = sq[62:2];
    end
  end

  // Stage 5: sum of the squares.
  always_comb begin
    s5_nxt = '0;
    for (int j = 0; j < DIM; j++) begin
      s5_nxt = s5_nxt + SW'(q4_r[j]);
    end
  end

  // Stage 6: outer and inner radius tests and the target radius.
  always_comb begin
    logic [31:0] rr;
    logic        sphere, ball, shell;
    rr     = 32'(cfg.irad) * 32'(cfg.irad);
    sphere = (cfg.mode == MODE_SPHERE);
    ball   = !sphere && (s5_r > (SW'(1) << 54));
    shell  = !sphere && !ball && (cfg.mode == MODE_SHELL) && (s5_r < SW'({rr, 22'b0}));
    side6_nxt.x    = x5_r;
    side6_nxt.meta = meta5_r;
    side6_nxt.need = sphere || ball || shell;
    side6_nxt.rq   = shell ? RW'({cfg.irad, 11'b0}) : (RW'(1) << 27);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= v_in;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      q4_r    <= q4_nxt;
      x4_r    <= x_in;
      meta4_r <= meta_in;
      s5_r    <= s5_nxt;
      x5_r    <= x4_r;
      meta5_r <= meta4_r;
      s6_r    <= s5_r;
      side6_r <= side6_nxt;
    end
  end

  assign v_out    = v6_r;
  assign s_out    = s6_r;
  assign side_out = side6_r;

endmodule

// File: rtl/core/pgs_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on pgs_pkg.
module pgs_sqrt import pgs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_in,
  input  logic [SW-1:0]   s_in,
  input  pgs_side_t       side_in,
  output logic            v_out,
  output logic [31:0]     n_out,
  output pgs_side_t       side_out
);

  logic [NS-1:0]  v_r, v_nxt;
  logic [SW-1:0]  rem_r  [NS];
  logic [SW-1:0]  rem_nxt[NS];
  logic [SW-1:0]  res_r  [NS];
  logic [SW-1:0]  res_nxt[NS];
  pgs_side_t      side_r  [NS];
  pgs_side_t      side_nxt[NS];

  // Each stage tries one bit of the root, from the top pair of bits down.
  always_comb begin
    logic [SW-1:0] rin, qin, bitv, trial;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rin         = s_in;
        qin         = '0;
        v_nxt[k]    = v_in;
        side_nxt[k] = side_in;
      end else begin
        rin         = rem_r[k-1];
        qin         = res_r[k-1];
        v_nxt[k]    = v_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      bitv  = SW'(1) << (62 - 2 * k);
      trial = qin + bitv;
      if (rin >= trial) begin
        rem_nxt[k] = rin - trial;
        res_nxt[k] = (qin >> 1) + bitv;
      end else begin
        rem_nxt[k] = rin;
        res_nxt[k] = qin >> 1;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      res_r  <= res_nxt;
      side_r <= side_nxt;
    end
  end

  assign v_out    = v_r[NS-1];
  assign n_out    = res_r[NS-1][31:0];
  assign side_out = side_r[NS-1];

endmodule

// File: rtl/core/pgs_scale.sv
// Rescaling stages: radius product, overflow check, pipelined divide by the norm
// and the final saturating output register. Depends on pgs_pkg.
module pgs_scale import pgs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [31:0]   n_in,
  input  pgs_side_t     side_in,
  output logic          v_out,
  output pgs_out_t      out_data
);

  logic                   va_r, vb_r, vf_r;
  logic [DIM-1:0][59:0]   numa_r, numa_nxt, numb_r;
  logic [31:0]            na_r, nb_r;
  pgs_dside_t             dsa_r, dsa_nxt, dsb_r;
  logic [DIM-1:0]         ovfb_nxt, ovfb_r;

  logic [QW-1:0]          vd_r, vd_nxt;
  logic [SW-1:0]          rem_r  [QW][DIM];
  logic [SW-1:0]          rem_nxt[QW][DIM];
  logic [QW-1:0]          q_r    [QW][DIM];
  logic [QW-1:0]          q_nxt  [QW][DIM];
  logic [DIM-1:0]         ovf_r  [QW];
  logic [DIM-1:0]         ovf_nxt[QW];
  logic [31:0]            n_r    [QW];
  logic [31:0]            n_nxt  [QW];
  pgs_dside_t             ds_r   [QW];
  pgs_dside_t             ds_nxt [QW];

  pgs_out_t               out_r, out_nxt;

  // Stage A: magnitude times target radius, plus half the norm for rounding.
  always_comb begin
    logic [31:0] mag;
    for (int j = 0; j < DIM; j++) begin
      mag         = side_in.x[j][XW-1] ? (~side_in.x[j] + 32'd1) : side_in.x[j];
      numa_nxt[j] = 60'(mag) * 60'(side_in.rq) + 60'(n_in >> 1);
    end
    dsa_nxt.x     = side_in.x;
    dsa_nxt.meta  = side_in.meta;
    dsa_nxt.scale = side_in.need && (n_in != 32'd0);
    dsa_nxt.deg   = side_in.need && (n_in == 32'd0);
  end

  // Stage B: a quotient of 2^32 or more saturates whatever its low bits are.
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      ovfb_nxt[j] = SW'(numa_r[j]) >= {na_r, 32'b0};
    end
  end

  // Divider: one quotient bit per stage, most significant first.
  always_comb begin
    logic [SW-1:0] rin, dv;
    logic [QW-1:0] qin;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        vd_nxt[k]  = vb_r;
        n_nxt[k]   = nb_r;
        ovf_nxt[k] = ovfb_r;
        ds_nxt[k]  = dsb_r;
      end else begin
        vd_nxt[k]  = vd_r[k-1];
        n_nxt[k]   = n_r[k-1];
        ovf_nxt[k] = ovf_r[k-1];
        ds_nxt[k]  = ds_r[k-1];
      end
      dv = SW'(n_nxt[k]) << (QW - 1 - k);
      for (int j = 0; j < DIM; j++) begin
        if (k == 0) begin
          rin = SW'(numb_r[j]);
          qin = '0;
        end else begin
          rin = rem_r[k-1][j];
          qin = q_r[k-1][j];
        end
        if (rin >= dv) begin
          rem_nxt[k][j] = rin - dv;
          q_nxt[k][j]   = qin | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_nxt[k][j] = rin;
          q_nxt[k][j]   = qin;
        end
      end
    end
  end

  // Final stage: restore the sign, saturate, or pass the point unscaled.
  always_comb begin
    logic [31:0]         q;
    logic                ovf;
    logic [DIM-1:0][31:0] y;
    pgs_dside_t          ds;
    ds = ds_r[QW-1];
    for (int j = 0; j < DIM; j++) begin
      q   = q_r[QW-1][j];
      ovf = ovf_r[QW-1][j];
      if (!ds.scale) begin
        y[j] = ds.x[j];
      end else if (ds.x[j][XW-1]) begin
        y[j] = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : (~q + 32'd1);
      end else begin
        y[j] = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
      end
    end
    out_nxt.new_0      = y[0];
    out_nxt.new_1      = y[1];
    out_nxt.new_2      = y[2];
    out_nxt.out_tag    = ds.meta.tag;
    out_nxt.out_last   = ds.meta.last;
    out_nxt.degenerate = ds.deg;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vd_r <= '0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
      vd_r <= vd_nxt;
      vf_r <= vd_r[QW-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      numa_r <= numa_nxt;
      na_r   <= n_in;
      dsa_r  <= dsa_nxt;
      numb_r <= numa_r;
      nb_r   <= na_r;
      dsb_r  <= dsa_r;
      ovfb_r <= ovfb_nxt;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      ovf_r  <= ovf_nxt;
      n_r    <= n_nxt;
      ds_r   <= ds_nxt;
      out_r  <= out_nxt;
    end
  end

  assign v_out    = vf_r;
  assign out_data = out_r;

endmodule

// File: dv/testbench.sv
// Self-checking bench for projected_gradient_step: descent step, then ball, shell or sphere projection.
// Depends on pgs_pkg and the projected_gradient_step RTL; it predicts every point in plain SystemVerilog.
module testbench;
  import pgs_pkg::*;

  // Scoreboard: predicts each moved and projected point and matches results in order.
  class point_scoreboard;
    logic [1:0]  mode;
    logic [31:0] step;
    logic [15:0] irad;
    pgs_out_t    pending[$];
    int          mismatches;

    function new();
      mode = MODE_BALL;
      step = '0;
      irad = '0;
      mismatches = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint scale_to(longint x, logic [63:0] rq, logic [63:0] n);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (x < 0) ? -x : x;
      q = (mag * rq + (n >> 1)) / n;
      return sat((x < 0) ? -longint'(q) : longint'(q));
    endfunction

    // Note an accepted input transfer: compute its expected result.
    function void note_point(pgs_in_t p);
      longint      xs[DIM];
      logic [31:0] pv[DIM];
      logic [47:0] gv[DIM];
      logic [127:0] prod;
      logic [63:0] gmag, d, s, n, rq, ax;
      logic        need, deg;
      pgs_out_t    r;
      pv[0] = p.pos_0; pv[1] = p.pos_1; pv[2] = p.pos_2;
      gv[0] = p.grad_0; gv[1] = p.grad_1; gv[2] = p.grad_2;
      s = 0;
      for (int j = 0; j < DIM; j++) begin
        gmag = gv[j][47] ? {16'd0, -gv[j]} : {16'd0, gv[j]};
        prod = gmag * step;
        d = (prod + (128'd1 << 27)) >> 28;
        if (gv[j][47]) xs[j] = sat(longint'(signed'(pv[j])) + longint'(d));
        else xs[j] = sat(longint'(signed'(pv[j])) - longint'(d));
        ax = (xs[j] < 0) ? -xs[j] : xs[j];
        s = s + ((ax * ax) >> 2);
      end
      need = 0;
      rq = 0;
      if (mode == MODE_SPHERE) begin
        need = 1;
        rq = 64'd1 << 27;
      end else if (s > (64'd1 << 54)) begin
        need = 1;
        rq = 64'd1 << 27;
      end else if (mode == MODE_SHELL && s < (({48'd0, irad} * irad) << 22)) begin
        need = 1;
        rq = {48'd0, irad} << 11;
      end
      deg = 0;
      if (need) begin
        n = int_sqrt(s);
        if (n == 0) deg = 1;
        else for (int j = 0; j < DIM; j++) xs[j] = scale_to(xs[j], rq, n);
      end
      r.new_0 = xs[0][31:0];
      r.new_1 = xs[1][31:0];
      r.new_2 = xs[2][31:0];
      r.out_tag = p.point_tag;
      r.out_last = p.in_last;
      r.degenerate = deg;
      pending.push_back(r);
    endfunction

    // Check an accepted result transfer against the oldest expectation.
    function void check_result(pgs_out_t got);
      pgs_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic     clk, rst_n;
  logic     cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_wdata;
  logic     in_valid, in_ready, out_valid, out_ready;
  pgs_in_t  in_data;
  pgs_out_t out_data;
  point_scoreboard board;
  int       idle_pct;
  int       stall_cycles;

  projected_gradient_step uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Result side: random back-pressure, checking on each transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    if (rst_n && (in_valid && in_ready || out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (stall_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(pgs_cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_MODE: board.mode = val[1:0];
      CFG_STEP: board.step = val;
      default:  board.irad = val[15:0];
    endcase
  endtask

  // Present one point and hold it until the transfer, with random idle cycles first.
  // Valid stays high after the transfer so that points can follow back to back.
  task automatic send_point(pgs_in_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_point(p);
  endtask

  // Stop sending and wait until every accepted point has come out.
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_grad(int kind);
    logic [47:0] g;
    g = 48'({$urandom, $urandom});
    case (kind)
      0: g = {{20{g[27]}}, g[27:0]};
      1: g = {{28{g[19]}}, g[19:0]};
      default: ;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rand_coord(int kind);
    logic [31:0] c;
    c = $urandom;
    case (kind)
      0: c = {{4{c[27]}}, c[27:0]};
      1: c = {{6{c[8]}}, c[25:0]} >>> 0;
      2: c = {{24{c[3]}}, c[7:0]};
      default: ;
    endcase
    return c;
  endfunction

  function automatic pgs_in_t rand_point();
    pgs_in_t p;
    int k;
    k = $urandom_range(3);
    p.pos_0 = rand_coord(k);
    p.pos_1 = rand_coord(k);
    p.pos_2 = rand_coord(k);
    k = $urandom_range(2);
    p.grad_0 = rand_grad(k);
    p.grad_1 = rand_grad(k);
    p.grad_2 = rand_grad(k);
    if ($urandom_range(9) == 0) begin
      p.pos_0 = 0; p.pos_1 = 0; p.pos_2 = 0;
      p.grad_0 = 0; p.grad_1 = 0; p.grad_2 = 0;
    end
    p.point_tag = 16'($urandom);
    p.in_last = 1'($urandom);
    return p;
  endfunction

  function automatic pgs_in_t make_point(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         logic [47:0] g, logic [15:0] tag);
    pgs_in_t p;
    p.pos_0 = a; p.pos_1 = b; p.pos_2 = c;
    p.grad_0 = g; p.grad_1 = -g; p.grad_2 = g;
    p.point_tag = tag;
    p.in_last = tag[0];
    return p;
  endfunction

  initial begin
    logic [31:0] steps[4];
    board = new();
    idle_pct = 20;
    stall_cycles = 0;
    rst_n = 0;
    cfg_we = 0; cfg_idx = CFG_MODE; cfg_wdata = 0;
    in_valid = 0; in_data = '0; out_ready = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: reset configuration, extremes, zero vector, each mode and an empty shell.
    send_point(make_point(32'h7fffffff, 32'h80000000, 0, 48'h0, 16'hffff));
    send_point(make_point(0, 0, 0, 48'h0, 16'h0000));
    send_point(make_point(32'h10000000, 0, 0, 48'h0, 16'h0001));
    drain();
    write_reg(CFG_STEP, 32'hffffffff);
    send_point(make_point(0, 0, 0, 48'h7fffffffffff, 16'h0002));
    send_point(make_point(0, 0, 0, 48'h800000000000, 16'h0003));
    send_point(make_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 48'h1, 16'h0004));
    drain();
    write_reg(CFG_MODE, MODE_SHELL);
    write_reg(CFG_IRAD, 16'hffff);
    write_reg(CFG_STEP, 32'h0);
    send_point(make_point(32'h00100000, 0, 0, 48'h0, 16'h0005));
    send_point(make_point(0, 0, 0, 48'h0, 16'h0006));
    send_point(make_point(32'h08000000, 32'h08000000, 0, 48'h0, 16'h0007));
    drain();
    write_reg(CFG_IRAD, 16'h0);
    send_point(make_point(0, 0, 0, 48'h0, 16'h0008));
    send_point(make_point(32'h00000001, 0, 0, 48'h0, 16'h0009));
    drain();
    write_reg(CFG_MODE, MODE_SPHERE);
    send_point(make_point(0, 0, 0, 48'h0, 16'h000a));
    send_point(make_point(32'h00000003, 32'hfffffffd, 32'h1, 48'h0, 16'h000b));
    send_point(make_point(32'h10000000, 0, 0, 48'h0, 16'h000c));
    drain();
    write_reg(CFG_MODE, 2'd3);
    send_point(make_point(32'h30000000, 32'h30000000, 0, 48'h0, 16'h000d));
    send_point(make_point(0, 0, 0, 48'h0, 16'h000e));
    drain();

    // Random phases across mode, step and inner radius settings.
    steps[0] = 32'h0; steps[1] = 32'hffffffff; steps[2] = 32'h00000100; steps[3] = 32'h10000000;
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(CFG_MODE, ph % 4);
      write_reg(CFG_STEP, (ph < 4) ? steps[ph] : $urandom);
      write_reg(CFG_IRAD, (ph == 5) ? 16'hffff : $urandom);
      idle_pct = (ph == 7) ? 0 : 20;
      for (int i = 0; i < 100; i++) send_point(rand_point());
      drain();
    end

    if (board.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
